/* src/lhrg_pkg.sv */
package lhrg_pkg;

    localparam int FACTOR_BITS = 40;
    localparam int SUMSQ_BITS  = 11;
    localparam int VALUE_BITS  = 48;
    localparam int VW_BITS     = 32;
    localparam int EWS_BITS    = 36;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_ADDR_BITS = 6;

    typedef logic t_alu_op;
    localparam t_alu_op ALU_ADD = 1'b0;
    localparam t_alu_op ALU_SUB = 1'b1;

    localparam logic [2:0] REG_MAX_FREQ    = 3'd0;
    localparam logic [2:0] REG_ROTOR_COUNT = 3'd1;
    localparam logic [2:0] REG_EDGE_COUNT  = 3'd2;
    localparam logic [2:0] REG_VERTEX_W    = 3'd3;
    localparam logic [2:0] REG_EDGE_W_SUM  = 3'd4;

endpackage

/* src/lhrg_alu.sv */
module lhrg_alu
    import lhrg_pkg::*;
#(
    parameter int W = 41
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  t_alu_op      i_op,
    output logic [W-1:0] o_sum,
    output logic         o_borrow
);

    logic [W:0] w_res;

    always_comb begin
        unique case (i_op)
            ALU_SUB: w_res = {1'b0, i_a} - {1'b0, i_b};
            default: w_res = {1'b0, i_a} + {1'b0, i_b};
        endcase
    end

    assign o_sum    = w_res[W-1:0];
    assign o_borrow = (i_op == ALU_SUB) && w_res[W];

endmodule

/* src/lattice_hamiltonian_row_generator.sv */
// Load transaction: no result.
// Row transaction: factor build over the nrot rotors, digit extraction by repeated subtraction,
// the diagonal, then each edge; range check, digit extraction and edge columns share one
// add/subtract unit; one row is worked on at a time.
// An out-of-range row gives its single result.
// Synchronous active-low reset resets control and configuration; the edge table is undefined.
module lattice_hamiltonian_row_generator
    import lhrg_pkg::*;
#(
    parameter int MAX_ROTORS     = 8,
    parameter int MAX_EDGES      = 16,
    parameter int ROW_INDEX_BITS = 40
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // edge_slot, rotor_a, rotor_b, edge_weight, row_index
    input  logic [((42+ROW_INDEX_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // kind
    input  logic                           i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // column_index, entry_value
    output logic [((ROW_INDEX_BITS+48+7)/8)*8-1:0] o_m_axis_tdata,
    output logic                           o_m_axis_tlast,
    // row_error
    output logic                           o_m_axis_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [CFG_ADDR_BITS-1:0]       paddr,
    input  logic [CFG_DATA_BITS-1:0]       pwdata,
    output logic [CFG_DATA_BITS-1:0]       prdata,
    output logic                           pready
);

    localparam int IW   = ROW_INDEX_BITS;
    localparam int AW   = ((IW > FACTOR_BITS) ? IW : FACTOR_BITS) + 1;
    localparam int EIW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EW   = $clog2(MAX_EDGES + 1);
    localparam int RIW  = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1;
    localparam int FIW  = $clog2(MAX_ROTORS + 1);
    localparam int ODW  = ((IW + 48 + 7) / 8) * 8;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FACT  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_DIG   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_DIAG  = 4'd5;
    localparam logic [3:0] S_EDGE  = 4'd6;
    localparam logic [3:0] S_RDA   = 4'd7;
    localparam logic [3:0] S_RDB   = 4'd8;
    localparam logic [3:0] S_CHK   = 4'd9;
    localparam logic [3:0] S_COLA  = 4'd10;
    localparam logic [3:0] S_COLB  = 4'd11;
    localparam logic [3:0] S_PUSH  = 4'd12;
    localparam logic [3:0] S_FLUSH = 4'd13;

    logic [3:0]                r_state;
    logic [3:0]                r_cfg_mf;
    logic [3:0]                r_cfg_rc;
    logic [4:0]                r_cfg_ec;
    logic [VW_BITS-1:0]        r_cfg_vw;
    logic [EWS_BITS-1:0]       r_cfg_ews;

    logic [2:0]                r_tab_a [MAX_EDGES];
    logic [2:0]                r_tab_b [MAX_EDGES];
    logic [31:0]               r_tab_w [MAX_EDGES];

    logic [FACTOR_BITS-1:0]    r_factor [MAX_ROTORS+1];
    logic [4:0]                r_digit  [MAX_ROTORS];

    logic [3:0]                r_m;
    logic [4:0]                r_base;
    logic [3:0]                r_nrot;
    logic [EW-1:0]             r_nedge;
    logic [IW-1:0]             r_row;
    logic [AW-1:0]             r_rest;
    logic [AW-1:0]             r_acc;
    logic [3:0]                r_d;
    logic [4:0]                r_cnt;
    logic [SUMSQ_BITS-1:0]     r_sumsq;
    logic signed [43:0]        r_prod;
    logic [EW-1:0]             r_e;
    logic [2:0]                r_ra;
    logic [2:0]                r_rb;
    logic [31:0]               r_w;
    logic [4:0]                r_da;
    logic [4:0]                r_db;
    logic                      r_f;

    logic                      r_pend_v;
    logic [IW-1:0]             r_pend_col;
    logic [VALUE_BITS-1:0]     r_pend_val;

    logic                      r_out_v;
    logic [IW-1:0]             r_out_col;
    logic [VALUE_BITS-1:0]     r_out_val;
    logic                      r_out_last;
    logic                      r_out_err;

    logic                      w_in_acc;
    logic                      w_cfg_wr;
    logic [2:0]                w_cfg_idx;
    logic                      w_out_free;
    logic                      w_out_load;
    logic [FIW-1:0]            w_fidx;
    logic [FACTOR_BITS-1:0]    w_factor;
    logic [AW-1:0]             w_alu_a;
    logic [AW-1:0]             w_alu_b;
    t_alu_op                   w_alu_op;
    logic [AW-1:0]             w_alu_sum;
    logic                      w_alu_borrow;
    logic [4:0]                w_dsel;
    logic signed [5:0]         w_off;
    logic signed [11:0]        w_sq;
    logic [VALUE_BITS-1:0]     w_diag;
    logic [VALUE_BITS-1:0]     w_negw;
    logic                      w_nb_ok;
    logic [4:0]                w_top;
    logic [EIW-1:0]            w_eidx;
    logic [3:0]                w_in_m;
    logic [3:0]                w_in_nrot;
    logic [3:0]                w_slot;

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_cfg_idx  = paddr[5:3];
    assign w_out_free = !r_out_v || i_m_axis_tready;
    assign w_out_load = w_out_free && (((r_state == S_CHECK) && !w_alu_borrow)
                                       || (r_state == S_PUSH) || (r_state == S_FLUSH));
    assign w_slot     = i_s_axis_tdata[3:0];
    assign w_eidx     = EIW'(r_e);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign pready          = 1'b1;

    always_comb begin
        unique case (w_cfg_idx)
            REG_MAX_FREQ:    prdata = CFG_DATA_BITS'(r_cfg_mf);
            REG_ROTOR_COUNT: prdata = CFG_DATA_BITS'(r_cfg_rc);
            REG_EDGE_COUNT:  prdata = CFG_DATA_BITS'(r_cfg_ec);
            REG_VERTEX_W:    prdata = CFG_DATA_BITS'(r_cfg_vw);
            REG_EDGE_W_SUM:  prdata = CFG_DATA_BITS'(r_cfg_ews);
            default:         prdata = '0;
        endcase
    end

    assign w_in_m = (r_cfg_mf == 4'd0) ? 4'd1 : r_cfg_mf;
    always_comb begin
        if (r_cfg_rc == 4'd0) begin
            w_in_nrot = 4'd1;
        end else if (32'(r_cfg_rc) > MAX_ROTORS) begin
            w_in_nrot = 4'(MAX_ROTORS);
        end else begin
            w_in_nrot = r_cfg_rc;
        end
    end

    always_comb begin
        unique case (r_state)
            S_CHECK: w_fidx = FIW'(r_nrot);
            S_COLA:  w_fidx = FIW'(r_ra);
            S_COLB:  w_fidx = FIW'(r_rb);
            default: w_fidx = FIW'(r_d);
        endcase
    end
    assign w_factor = r_factor[w_fidx];

    always_comb begin
        w_alu_b = AW'(w_factor);
        unique case (r_state)
            S_CHECK: begin
                w_alu_a  = AW'(r_row);
                w_alu_op = ALU_SUB;
            end
            S_DIG: begin
                w_alu_a  = r_rest;
                w_alu_op = ALU_SUB;
            end
            S_COLA: begin
                w_alu_a  = r_acc;
                w_alu_op = r_f ? ALU_SUB : ALU_ADD;
            end
            default: begin
                w_alu_a  = r_acc;
                w_alu_op = r_f ? ALU_ADD : ALU_SUB;
            end
        endcase
    end

    lhrg_alu #(.W(AW)) u_alu (
        .i_a      (w_alu_a),
        .i_b      (w_alu_b),
        .i_op     (w_alu_op),
        .o_sum    (w_alu_sum),
        .o_borrow (w_alu_borrow)
    );

    assign w_dsel = (r_state == S_RDA) ? r_digit[RIW'(r_ra)] : r_digit[RIW'(r_rb)];
    assign w_off  = $signed({1'b0, r_cnt}) - $signed({2'b00, r_m});
    assign w_sq   = w_off * w_off;
    assign w_diag = {{5{r_prod[43]}}, r_prod[43:1]}
                  + {{11{r_cfg_ews[EWS_BITS-1]}}, r_cfg_ews, 1'b0};
    assign w_negw = VALUE_BITS'(0) - {{16{r_w[31]}}, r_w};
    assign w_top  = {r_m, 1'b0};

    always_comb begin
        if (r_ra == r_rb) begin
            w_nb_ok = 1'b1;
        end else if (!r_f) begin
            w_nb_ok = (r_da < w_top) && (r_db != 5'd0);
        end else begin
            w_nb_ok = (r_da != 5'd0) && (r_db < w_top);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && !i_s_axis_tuser && (32'(w_slot) < MAX_EDGES)) begin
            r_tab_a[EIW'(w_slot)] <= i_s_axis_tdata[6:4];
            r_tab_b[EIW'(w_slot)] <= i_s_axis_tdata[9:7];
            r_tab_w[EIW'(w_slot)] <= i_s_axis_tdata[41:10];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mf  <= 4'd1;
            r_cfg_rc  <= 4'd1;
            r_cfg_ec  <= '0;
            r_cfg_vw  <= '0;
            r_cfg_ews <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_MAX_FREQ:    r_cfg_mf  <= pwdata[3:0];
                REG_ROTOR_COUNT: r_cfg_rc  <= pwdata[3:0];
                REG_EDGE_COUNT:  r_cfg_ec  <= pwdata[4:0];
                REG_VERTEX_W:    r_cfg_vw  <= pwdata[VW_BITS-1:0];
                REG_EDGE_W_SUM:  r_cfg_ews <= pwdata[EWS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_load) begin
            r_out_v <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend_v <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_s_axis_tuser) begin
                        r_m         <= w_in_m;
                        r_base      <= {w_in_m, 1'b1};
                        r_nrot      <= w_in_nrot;
                        r_nedge     <= (32'(r_cfg_ec) > MAX_EDGES) ? EW'(MAX_EDGES)
                                                                   : EW'(r_cfg_ec);
                        r_row       <= i_s_axis_tdata[42+IW-1:42];
                        r_factor[0] <= FACTOR_BITS'(1);
                        r_d         <= 4'd0;
                        r_state     <= S_FACT;
                    end
                end
                S_FACT: begin
                    r_factor[FIW'(r_d + 4'd1)] <= FACTOR_BITS'(w_factor * r_base);
                    r_d <= r_d + 4'd1;
                    if (r_d + 4'd1 == r_nrot) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!w_alu_borrow) begin
                        if (w_out_free) begin
                            r_out_col  <= r_row;
                            r_out_val  <= '0;
                            r_out_last <= 1'b1;
                            r_out_err  <= 1'b1;
                            r_state    <= S_IDLE;
                        end
                    end else begin
                        r_rest  <= AW'(r_row);
                        r_d     <= r_nrot - 4'd1;
                        r_cnt   <= '0;
                        r_sumsq <= '0;
                        r_state <= S_DIG;
                    end
                end
                S_DIG: begin
                    if (!w_alu_borrow) begin
                        r_rest <= w_alu_sum;
                        r_cnt  <= r_cnt + 5'd1;
                    end else begin
                        r_digit[RIW'(r_d)] <= r_cnt;
                        r_sumsq <= r_sumsq + SUMSQ_BITS'(w_sq);
                        r_cnt   <= '0;
                        if (r_d == 4'd0) begin
                            r_state <= S_MUL;
                        end else begin
                            r_d <= r_d - 4'd1;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= $signed(r_cfg_vw) * $signed({1'b0, r_sumsq});
                    r_state <= S_DIAG;
                end
                S_DIAG: begin
                    r_pend_v   <= 1'b1;
                    r_pend_col <= r_row;
                    r_pend_val <= w_diag;
                    r_e        <= '0;
                    r_state    <= S_EDGE;
                end
                S_EDGE: begin
                    if (r_e == r_nedge) begin
                        r_state <= S_FLUSH;
                    end else if ((r_tab_a[w_eidx] >= 3'(r_nrot) && r_nrot != 4'd8)
                              || (r_tab_b[w_eidx] >= 3'(r_nrot) && r_nrot != 4'd8)) begin
                        r_e <= r_e + EW'(1);
                    end else begin
                        r_ra    <= r_tab_a[w_eidx];
                        r_rb    <= r_tab_b[w_eidx];
                        r_w     <= r_tab_w[w_eidx];
                        r_f     <= 1'b0;
                        r_state <= S_RDA;
                    end
                end
                S_RDA: begin
                    r_da    <= w_dsel;
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_db    <= w_dsel;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (w_nb_ok) begin
                        r_acc   <= AW'(r_row);
                        r_state <= S_COLA;
                    end else if (!r_f) begin
                        r_f <= 1'b1;
                    end else begin
                        r_e     <= r_e + EW'(1);
                        r_state <= S_EDGE;
                    end
                end
                S_COLA: begin
                    r_acc   <= w_alu_sum;
                    r_state <= S_COLB;
                end
                S_COLB: begin
                    r_acc   <= w_alu_sum;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (w_out_free) begin
                        r_out_col  <= r_pend_col;
                        r_out_val  <= r_pend_val;
                        r_out_last <= 1'b0;
                        r_out_err  <= 1'b0;
                        r_pend_col <= r_acc[IW-1:0];
                        r_pend_val <= w_negw;
                        if (!r_f) begin
                            r_f     <= 1'b1;
                            r_state <= S_CHK;
                        end else begin
                            r_e     <= r_e + EW'(1);
                            r_state <= S_EDGE;
                        end
                    end
                end
                S_FLUSH: begin
                    if (w_out_free) begin
                        r_out_col  <= r_pend_col;
                        r_out_val  <= r_pend_val;
                        r_out_last <= 1'b1;
                        r_out_err  <= 1'b0;
                        r_pend_v   <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = ODW'({r_out_val, r_out_col});
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_err;

    a_ready_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !r_pend_v)
        else $error("input ready while a result is still pending");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_err |-> r_out_last)
        else $error("row error result without last");

    a_row_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_s_axis_tuser |=> !o_s_axis_tready)
        else $error("ready right after a row transaction");

endmodule
